// ===== rtl/tdrs_pkg.sv =====
package tdrs_pkg;

	typedef enum logic [1:0] {
		OP_SENT   = 2'd0,
		OP_ACKED  = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic [31:0] send_stamp;
		logic [31:0] delivered_stamp;
		logic [31:0] first_send_stamp;
		logic [31:0] delivered_count;
		logic        app_limited;
	} slot_entry_t;

	localparam logic [31:0] INVALID_VALUE = 32'hFFFF_FFFF;

	// a is later than b in wrap-around order
	function automatic logic later_than(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && !d[31];
	endfunction

endpackage

// ===== rtl/tcp_delivery_rate_sampler.sv =====
// Delivery-rate sampler for one TCP connection.
// Input channel (in_valid/in_ready) carries one event word: packet sent,
// packet acked or sacked, or take a rate sample. Output channel
// (out_valid/out_ready) returns one result word per event; the unused
// opcode returns nothing.
// Per-slot snapshots live in one synchronous memory of PACKET_SLOTS
// entries. An accepted word issues the memory read on its accept edge;
// the execute state that follows computes the result, writes the slot
// back and loads the output register. The block takes no new word
// until execute has finished with the current one.
// Because the next word is only accepted after the write-back, a read
// never overlaps a pending write of the same slot.
// A new word is accepted while an earlier result still waits in the
// output register; if the receiver stalls, the block holds the computed
// word in its execute cycle until the output register frees up.
// Reset clears the connection state and the handshake; slot memory
// contents are undefined until a sent event writes them.
module tcp_delivery_rate_sampler
	import tdrs_pkg::*;
#(
	parameter int PACKET_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [31:0]        now,
	input  logic [5:0]         slot,
	input  logic [31:0]        in_flight,
	input  logic [31:0]        delivered_count,
	input  logic [31:0]        app_limited_mark,
	input  logic               sacked,
	input  logic               acked_sacked,
	input  logic [31:0]        lost,
	input  logic [30:0]        min_rtt,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] delivered_increment,
	output logic signed [31:0] sample_interval,
	output logic [31:0]        losses,
	output logic               sample_app_limited,
	output logic [31:0]        app_limited_out,
	output logic               snapshot_taken
);

	localparam int AW = (PACKET_SLOTS > 1) ? $clog2(PACKET_SLOTS) : 1;

	state_t      state_q;
	op_t         op_q;
	logic [31:0] now_q;
	logic [31:0] flight_q;
	logic [31:0] dcount_q;
	logic [31:0] alm_q;
	logic        sacked_q;
	logic        acked_sacked_q;
	logic [31:0] lost_q;
	logic [30:0] min_rtt_q;
	logic [AW-1:0] addr_q;
	logic        in_range_q;

	logic [31:0] conn_delivered_q, conn_delivered_d;
	logic [31:0] conn_first_q, conn_first_d;
	logic [31:0] prior_count_q, prior_count_d;
	logic [31:0] prior_ack_q, prior_ack_d;
	logic        window_al_q, window_al_d;
	logic [31:0] pending_q, pending_d;

	slot_entry_t mem [PACKET_SLOTS];
	slot_entry_t rd_entry_q;
	slot_entry_t wr_data;
	logic        wr_en;

	logic        accept;
	logic        done;
	logic        out_valid_q;
	logic [12:0] slot_wide;

	logic [31:0] res_incr, res_iv, res_losses, res_alm;
	logic        res_sal, res_snap;

	logic [31:0]        cd_new, cf_new;
	logic [31:0]        alm_new;
	logic signed [31:0] snd_iv, ack_iv, max_iv;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign done      = (state_q == ST_EXEC) && (!out_valid_q || out_ready || op_q == OP_NONE);
	assign out_valid = out_valid_q;
	assign slot_wide = 13'(slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q           <= op_t'(opcode);
			now_q          <= now;
			flight_q       <= in_flight;
			dcount_q       <= delivered_count;
			alm_q          <= app_limited_mark;
			sacked_q       <= sacked;
			acked_sacked_q <= acked_sacked;
			lost_q         <= lost;
			min_rtt_q      <= min_rtt;
			addr_q         <= slot_wide[AW-1:0];
			in_range_q     <= slot_wide < 13'(PACKET_SLOTS);
		end
	end

	// slot memory: read on accept, write back at the end of execute
	always_ff @(posedge clk) begin
		if (done && wr_en) mem[addr_q] <= wr_data;
		if (accept) rd_entry_q <= mem[slot_wide[AW-1:0]];
	end

	always_comb begin
		conn_delivered_d = conn_delivered_q;
		conn_first_d     = conn_first_q;
		prior_count_d    = prior_count_q;
		prior_ack_d      = prior_ack_q;
		window_al_d      = window_al_q;
		pending_d        = pending_q;
		wr_en            = 1'b0;
		wr_data          = rd_entry_q;
		res_incr         = '0;
		res_iv           = '0;
		res_losses       = '0;
		res_alm          = '0;
		res_sal          = 1'b0;
		res_snap         = 1'b0;
		cd_new           = (flight_q == 32'd0) ? now_q : conn_delivered_q;
		cf_new           = (flight_q == 32'd0) ? now_q : conn_first_q;
		alm_new          = (alm_q != 32'd0 && later_than(dcount_q, alm_q)) ? 32'd0 : alm_q;
		snd_iv           = signed'(pending_q);
		ack_iv           = signed'(now_q - prior_ack_q);
		max_iv           = (snd_iv > ack_iv) ? snd_iv : ack_iv;
		unique case (op_q)
			OP_SENT: begin
				if (in_range_q) begin
					conn_delivered_d         = cd_new;
					conn_first_d             = cf_new;
					wr_en                    = 1'b1;
					wr_data.send_stamp       = now_q;
					wr_data.delivered_stamp  = cd_new;
					wr_data.first_send_stamp = cf_new;
					wr_data.delivered_count  = dcount_q;
					wr_data.app_limited      = (alm_q != 32'd0);
				end
			end
			OP_ACKED: begin
				// zero delivered stamp marks a slot already used
				if (in_range_q && rd_entry_q.delivered_stamp != 32'd0) begin
					if (prior_count_q == 32'd0 ||
						later_than(rd_entry_q.delivered_count, prior_count_q)) begin
						prior_count_d = rd_entry_q.delivered_count;
						prior_ack_d   = rd_entry_q.delivered_stamp;
						window_al_d   = rd_entry_q.app_limited;
						pending_d     = rd_entry_q.send_stamp - rd_entry_q.first_send_stamp;
						conn_first_d  = rd_entry_q.send_stamp;
						res_snap      = 1'b1;
					end
					if (sacked_q) begin
						wr_en                   = 1'b1;
						wr_data.delivered_stamp = 32'd0;
					end
				end
			end
			OP_SAMPLE: begin
				if (acked_sacked_q) conn_delivered_d = now_q;
				res_losses = lost_q;
				res_sal    = window_al_q;
				res_alm    = alm_new;
				if (prior_ack_q == 32'd0) begin
					pending_d = INVALID_VALUE;
					res_incr  = INVALID_VALUE;
					res_iv    = INVALID_VALUE;
				end else begin
					res_incr = dcount_q - prior_count_q;
					res_iv   = (max_iv < signed'({1'b0, min_rtt_q})) ? INVALID_VALUE
						: unsigned'(max_iv);
					pending_d = res_iv;
				end
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_delivered_q <= '0;
			conn_first_q     <= '0;
			prior_count_q    <= '0;
			prior_ack_q      <= '0;
			window_al_q      <= 1'b0;
			pending_q        <= '0;
		end else if (done) begin
			conn_delivered_q <= conn_delivered_d;
			conn_first_q     <= conn_first_d;
			prior_count_q    <= prior_count_d;
			prior_ack_q      <= prior_ack_d;
			window_al_q      <= window_al_d;
			pending_q        <= pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && op_q != OP_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && op_q != OP_NONE) begin
			delivered_increment <= signed'(res_incr);
			sample_interval     <= signed'(res_iv);
			losses              <= res_losses;
			sample_app_limited  <= res_sal;
			app_limited_out     <= res_alm;
			snapshot_taken      <= res_snap;
		end
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted word did not enter execute");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result word appeared without an execute cycle");

	a_exec_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && !out_valid_q) |=> state_q == ST_IDLE)
		else $error("execute stalled with a free output register");

endmodule
